// ----- src/ss_pkg.sv -----
// Shared types, request codes and status codes of the sortable stack.
package ss_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_W   = 5;
    localparam int DEF_DEPTH = 16;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_SORT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    // One result beat from the sequencer: strobe, status and the current top entry.
    typedef struct packed {
        logic                     strobe;
        status_t                  status;
        logic signed [DATA_W-1:0] top;
    } res_t;

endpackage

// ----- src/ss_ram.sv -----
// Entry store of the stack: one write port and one read port with registered read data.
module ss_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [AW-1:0]                    waddr,
    input  logic signed [ss_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]                    raddr,
    output logic signed [ss_pkg::DATA_W-1:0] rdata
);
    import ss_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data registered.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- src/ss_cmp.sv -----
// Signed compare unit used by the sort sequencer.
module ss_cmp (
    input  logic signed [ss_pkg::DATA_W-1:0] a,
    input  logic signed [ss_pkg::DATA_W-1:0] b,
    output logic                             a_gt_b
);
    import ss_pkg::*;

    // True when the lower entry must move up past the key.
    assign a_gt_b = (a > b);

endmodule

// ----- src/ss_ctrl.sv -----
// Request sequencer: push, pop and peek handling and the insertion sort over the entry store.
module ss_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  ss_pkg::op_t                      op,
    input  logic signed [ss_pkg::DATA_W-1:0] value,
    output logic                             busy,
    output ss_pkg::res_t                     res,
    output logic [CW-1:0]                    count,
    output logic                             we,
    output logic [AW-1:0]                    waddr,
    output logic signed [ss_pkg::DATA_W-1:0] wdata,
    output logic [AW-1:0]                    raddr,
    input  logic signed [ss_pkg::DATA_W-1:0] rdata
);
    import ss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEYW,
        S_CMP,
        S_PLACE,
        S_TOPRD,
        S_LOADTOP
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            i_reg, i_next;
    logic [AW-1:0]            j_reg, j_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    status_t                  status_reg, status_next;
    logic                     strobe_reg, strobe_next;
    logic                     gt;
    logic [CW-1:0]            cnt_m1;
    logic [CW-1:0]            cnt_m2;
    logic [CW-1:0]            i_p1;

    ss_cmp u_cmp (
        .a      (rdata),
        .b      (key_reg),
        .a_gt_b (gt)
    );

    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);
    assign i_p1   = i_reg + CW'(1);

    // Next-state logic and store access.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        key_next    = key_reg;
        top_next    = top_reg;
        status_next = status_reg;
        strobe_next = 1'b0;
        we          = 1'b0;
        waddr       = count_reg[AW-1:0];
        wdata       = value;
        raddr       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = ST_OK;
                    unique case (op)
                        OP_PUSH:
                        begin
                            strobe_next = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                we         = 1'b1;
                                top_next   = value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                strobe_next = 1'b1;
                            end
                            else if (count_reg == CW'(1))
                            begin
                                count_next  = '0;
                                strobe_next = 1'b1;
                            end
                            else
                            begin
                                // Fetch the entry that becomes the new top.
                                count_next = cnt_m1;
                                raddr      = cnt_m2[AW-1:0];
                                state_next = S_LOADTOP;
                            end
                        end
                        OP_PEEK:
                        begin
                            strobe_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                        end
                        OP_SORT:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                strobe_next = 1'b1;
                            end
                            else
                            begin
                                i_next     = CW'(1);
                                raddr      = AW'(1);
                                state_next = S_KEYW;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end
            S_KEYW:
            begin
                // Latch the key and fetch its lower neighbour.
                key_next   = rdata;
                j_next     = i_reg[AW-1:0];
                raddr      = i_reg[AW-1:0] - AW'(1);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (gt)
                begin
                    // Move the larger entry up one place.
                    we     = 1'b1;
                    waddr  = j_reg;
                    wdata  = rdata;
                    j_next = j_reg - AW'(1);
                    if (j_reg > AW'(1))
                    begin
                        raddr = j_reg - AW'(2);
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                we     = 1'b1;
                waddr  = j_reg;
                wdata  = key_reg;
                i_next = i_p1;
                if (i_p1 < count_reg)
                begin
                    raddr      = i_p1[AW-1:0];
                    state_next = S_KEYW;
                end
                else
                begin
                    state_next = S_TOPRD;
                end
            end
            S_TOPRD:
            begin
                raddr      = cnt_m1[AW-1:0];
                state_next = S_LOADTOP;
            end
            S_LOADTOP:
            begin
                top_next    = rdata;
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
            status_reg <= ST_OK;
            top_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
            status_reg <= status_next;
            top_reg    <= top_next;
        end
    end

    // Working registers, no reset needed.
    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        key_reg <= key_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign count      = count_reg;
    assign res.strobe = strobe_reg;
    assign res.status = status_reg;
    assign res.top    = top_reg;

endmodule

// ----- src/sortable_stack_core.sv -----
// Top level of the sortable stack: sequencer, entry store and result formatting.
//
// Channel   Direction  Handshake            Beat fields
// request   in         start && !busy       op, value
// result    out        done (one cycle)     status, top_value, depth
//
// Push, peek, sort of fewer than two entries and a pop that empties or finds the stack
// empty: the result beat follows in the cycle after acceptance, with busy staying low.
// Pop that leaves entries: busy for one cycle while the new top is read, then the beat.
// Sort of n entries: busy while each key is read, moved down past larger entries that shift
// up, and placed, then while the new top is read; then the beat (at most n*(n-1)/2 moves).
// Reset clears the fill count and the sequencer; the result beat cannot be stalled.
module sortable_stack_core #(
    parameter int DEPTH = ss_pkg::DEF_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        op,
    input  logic signed [ss_pkg::DATA_W-1:0]  value,
    output logic                              done,
    output logic [1:0]                        status,
    output logic signed [ss_pkg::DATA_W-1:0]  top_value,
    output logic [ss_pkg::DEPTH_W-1:0]        depth
);
    import ss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    res_t                     res;
    logic [CW-1:0]            count;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic [AW-1:0]            raddr;
    logic signed [DATA_W-1:0] wdata;
    logic signed [DATA_W-1:0] rdata;
    op_t                      op_code;

    assign op_code = op_t'(op);

    ss_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op_code),
        .value (value),
        .busy  (busy),
        .res   (res),
        .count (count),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    ss_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Result beat: an empty stack reports all ones as its top.
    assign done      = res.strobe;
    assign status    = res.status;
    assign top_value = (count == '0) ? '1 : res.top;
    assign depth     = DEPTH_W'(count);

    // Overflow is reported only with a full stack.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_OVERFLOW) |-> (count == CW'(DEPTH)))
        else $error("overflow reported while the stack has room");

    // A result beat is only issued with the sequencer back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat issued while busy");

    // Push and peek give their result in the next cycle.
    a_fast_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op_code == OP_PUSH || op_code == OP_PEEK)) |=> done)
        else $error("push or peek result missing");

    // The fill count never exceeds the capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(DEPTH))
        else $error("fill count beyond capacity");

endmodule

// ----- tb/sortable_stack_core_tb.sv -----
// Self-checking testbench for the sortable stack core: random request beats against a mirror.
`timescale 1ns / 1ps

module sortable_stack_core_tb;

    import ss_pkg::*;

    localparam int DEPTH        = DEF_DEPTH;
    localparam int RANDOM_ITEMS = 1725;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int SETTLE       = 20;
    localparam int REPORT_MAX   = 10;

    // Phases of the random part, each pulling the fill level a different way.
    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } mode_t;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] top;
        logic [DEPTH_W-1:0]       depth;
    } stack_result_t;

    // Mirror of the stack: it applies each accepted request and holds the results owed.
    class stack_scoreboard;
        logic signed [DATA_W-1:0] slots [DEPTH];
        int                       held;
        stack_result_t            owed [$];
        int                       mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Apply one accepted request beat and queue the result it must give.
        function void note_request(op_t kind, logic signed [DATA_W-1:0] data);
            stack_result_t            r;
            logic signed [DATA_W-1:0] key;
            int                       i;
            int                       j;
            r.status = ST_OK;
            case (kind)
                OP_PUSH:
                begin
                    if (held < DEPTH)
                    begin
                        slots[held] = data;
                        held++;
                    end
                    else
                        r.status = ST_OVERFLOW;
                end
                OP_POP:
                begin
                    if (held > 0)
                        held--;
                    else
                        r.status = ST_EMPTY;
                end
                OP_PEEK:
                begin
                    if (held == 0)
                        r.status = ST_EMPTY;
                end
                default:
                begin
                    // Insertion sort, ascending from bottom to top, signed compare.
                    for (i = 1; i < held; i++)
                    begin
                        key = slots[i];
                        j   = i;
                        while (j > 0 && slots[j-1] > key)
                        begin
                            slots[j] = slots[j-1];
                            j--;
                        end
                        slots[j] = key;
                    end
                end
            endcase
            r.top   = (held > 0) ? slots[held-1] : '1;
            r.depth = DEPTH_W'(held);
            owed.push_back(r);
        endfunction

        // Compare one result beat with the oldest result owed.
        function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] top,
                                   logic [DEPTH_W-1:0] dep);
            stack_result_t r;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result beat with none owed: status %0d top %0d depth %0d",
                             $realtime, st, top, dep);
                return;
            end
            r = owed.pop_front();
            if (st !== r.status || top !== r.top || dep !== r.depth)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: mismatch: status %0d/%0d top %0d/%0d depth %0d/%0d (exp/got)",
                             $realtime, r.status, st, r.top, top, r.depth, dep);
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                op;
    logic signed [DATA_W-1:0]  value;
    logic                      done;
    logic [1:0]                status;
    logic signed [DATA_W-1:0]  top_value;
    logic [DEPTH_W-1:0]        depth;

    stack_scoreboard sb;
    int              cycle_count = 0;

    sortable_stack_core #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .value    (value),
        .done     (done),
        .status   (status),
        .top_value(top_value),
        .depth    (depth)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Every result beat is taken at the edge that closes its strobe cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(status, top_value, depth);
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[sortable_stack_core] ERROR");
            $finish;
        end
    end

    // Present one request beat and hold it until the block takes it.
    task automatic send_request(input op_t kind, input logic signed [DATA_W-1:0] data);
        start <= 1'b1;
        op    <= kind;
        value <= data;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(kind, data);
    endtask

    // Hold off until every owed result has come back.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        mode_t                    mode;
        op_t                      kind;
        logic signed [DATA_W-1:0] data;
        int                       mode_left;
        int                       burst_left;
        int                       sel;
        int                       n;
        int                       k;

        sb    = new();
        rst_n = 1'b0;
        start = 1'b0;
        op    = OP_PEEK;
        value = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty-stack cases, value extremes, ties and a full stack.
        send_request(OP_PEEK, 32'h7fff_ffff);
        send_request(OP_POP, 32'h8000_0000);
        send_request(OP_SORT, '1);
        send_request(OP_PUSH, 32'h7fff_ffff);
        send_request(OP_SORT, '0);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_PUSH, '1);
        send_request(OP_PUSH, '0);
        send_request(OP_PUSH, 32'sd1);
        send_request(OP_SORT, 32'h5555_aaaa);
        send_request(OP_PEEK, 32'haaaa_5555);
        send_request(OP_POP, '0);
        // Descending values with repeats give the sort many moves and some ties.
        for (k = 0; k < DEPTH - 3; k++)
            send_request(OP_PUSH, (k % 4 == 0) ? 5 : 900 - 50 * k);
        send_request(OP_PUSH, 32'sd77);
        send_request(OP_SORT, '0);
        start <= 1'b0;
        wait_drained();

        // Random part: bursts of beats with gaps, phases that fill and drain the stack.
        mode       = MODE_MIXED;
        mode_left  = 0;
        burst_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (mode_left == 0)
            begin
                sel       = $urandom_range(2);
                mode      = (sel == 0) ? MODE_FILL : (sel == 1) ? MODE_DRAIN : MODE_MIXED;
                mode_left = $urandom_range(80, 20);
            end
            mode_left--;

            if (burst_left == 0)
            begin
                start <= 1'b0;
                if ($urandom_range(15) == 0)
                    wait_drained();
                else
                    repeat ($urandom_range(12, 1)) @(posedge clk);
                // Mostly short bursts, now and then a long stretch with no gaps.
                burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20)
                                                      : $urandom_range(8, 1);
            end
            burst_left--;

            sel = $urandom_range(99);
            case (mode)
                MODE_FILL:
                    kind = (sel < 55) ? OP_PUSH : (sel < 70) ? OP_POP :
                           (sel < 85) ? OP_PEEK : OP_SORT;
                MODE_DRAIN:
                    kind = (sel < 15) ? OP_PUSH : (sel < 70) ? OP_POP :
                           (sel < 85) ? OP_PEEK : OP_SORT;
                default:
                    kind = (sel < 30) ? OP_PUSH : (sel < 60) ? OP_POP :
                           (sel < 80) ? OP_PEEK : OP_SORT;
            endcase

            // Full-range values, a narrow band to force ties, and the extremes.
            sel = $urandom_range(99);
            if (sel < 60)
                data = $urandom;
            else if (sel < 85)
                data = $signed($urandom_range(16)) - 8;
            else
            begin
                case ($urandom_range(3))
                    0:       data = 32'h8000_0000;
                    1:       data = 32'h7fff_ffff;
                    2:       data = '1;
                    default: data = '0;
                endcase
            end

            send_request(kind, data);
        end

        // Let the last beats come back, then give the block time to show stray ones.
        start <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[sortable_stack_core] OK");
        else
            $display("[sortable_stack_core] ERROR");
        $finish;
    end

endmodule
